// ----- hw/rtl/cte_pkg.sv -----
// shared types and codes for the cursor text buffer
package cte_pkg;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_LEFT   = 3'd1;
  localparam logic [2:0] OP_RIGHT  = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_EDGE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] char_in;
    logic [9:0] read_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic        char_valid;
    logic [10:0] cursor_pos;
    logic [10:0] text_length;
    logic [1:0]  status;
  } result_t;

endpackage

// ----- hw/rtl/cte_mem.sv -----
// gap buffer byte store: one write port, one registered read port
module cte_mem #(
  parameter int CAPACITY = 1024,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] store [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/cte_ctrl.sv -----
// gap buffer sequencer: counters, address generation and result register
module cte_ctrl #(
  parameter int CAPACITY = 1024,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cte_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output cte_pkg::result_t result,
  output logic             mem_rd_en,
  output logic [AW-1:0]    mem_rd_addr,
  input  logic [7:0]       mem_rd_data,
  output logic             mem_wr_en,
  output logic [AW-1:0]    mem_wr_addr,
  output logic [7:0]       mem_wr_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > 10) ? CW : 10) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CMPW-1:0] CAP_X = CMPW'(CAPACITY);

  cte_pkg::state_t state, state_next;

  logic [CW-1:0] left, left_next;
  logic [CW-1:0] right, right_next;
  logic [2:0]    op_q;
  logic [7:0]    ch_q;
  logic          hit_q;

  logic          accept;
  logic [CMPW-1:0] idx_x, left_x, right_x, mapped_x, left_next_x, len_next_x;
  logic          in_left, in_text, full;
  logic [1:0]    status_next;
  logic [CW-1:0] left_dec, right_top, top_slot;

  assign accept = start && (state == cte_pkg::S_IDLE);
  assign busy   = (state == cte_pkg::S_EXEC);

  // read side address, from the incoming item
  assign idx_x    = CMPW'(item.read_index);
  assign left_x   = CMPW'(left);
  assign right_x  = CMPW'(right);
  assign in_left  = idx_x < left_x;
  assign in_text  = idx_x < (left_x + right_x);
  assign mapped_x = CAP_X - right_x + (idx_x - left_x);
  assign left_dec  = left - 1'b1;
  assign right_top = CAP_C - right;
  assign top_slot  = CAP_C - right - 1'b1;
  assign full      = (left_x + right_x) >= CAP_X;

  always_comb begin
    mem_rd_en   = accept;
    mem_rd_addr = '0;
    unique case (item.operation)
      cte_pkg::OP_LEFT:  mem_rd_addr = left_dec[AW-1:0];
      cte_pkg::OP_RIGHT: mem_rd_addr = right_top[AW-1:0];
      cte_pkg::OP_READ:  mem_rd_addr = in_left ? idx_x[AW-1:0] : mapped_x[AW-1:0];
      default:           mem_rd_addr = '0;
    endcase
  end

  // state machine and write-back
  always_comb begin
    state_next  = state;
    left_next   = left;
    right_next  = right;
    status_next = cte_pkg::ST_DONE;
    mem_wr_en   = 1'b0;
    mem_wr_addr = left[AW-1:0];
    mem_wr_data = ch_q;
    unique case (state)
      cte_pkg::S_IDLE: begin
        if (accept) begin
          state_next = cte_pkg::S_EXEC;
        end
      end
      cte_pkg::S_EXEC: begin
        state_next = cte_pkg::S_IDLE;
        unique case (op_q)
          cte_pkg::OP_INSERT: begin
            if (full) begin
              status_next = cte_pkg::ST_FULL;
            end else begin
              mem_wr_en = 1'b1;
              left_next = left + 1'b1;
            end
          end
          cte_pkg::OP_LEFT: begin
            if (left == '0) begin
              status_next = cte_pkg::ST_EDGE;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = top_slot[AW-1:0];
              mem_wr_data = mem_rd_data;
              left_next   = left - 1'b1;
              right_next  = right + 1'b1;
            end
          end
          cte_pkg::OP_RIGHT: begin
            if (right == '0) begin
              status_next = cte_pkg::ST_EDGE;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_data = mem_rd_data;
              left_next   = left + 1'b1;
              right_next  = right - 1'b1;
            end
          end
          cte_pkg::OP_DELETE: begin
            if (left == '0) begin
              status_next = cte_pkg::ST_EDGE;
            end else begin
              left_next = left - 1'b1;
            end
          end
          cte_pkg::OP_READ: begin
            status_next = cte_pkg::ST_DONE;
          end
          default: begin
            status_next = cte_pkg::ST_EDGE;
          end
        endcase
      end
      default: state_next = cte_pkg::S_IDLE;
    endcase
  end

  assign left_next_x = CMPW'(left_next);
  assign len_next_x  = CMPW'(left_next) + CMPW'(right_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cte_pkg::S_IDLE;
      left  <= '0;
      right <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      left  <= left_next;
      right <= right_next;
      done  <= (state == cte_pkg::S_EXEC);
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= item.operation;
      ch_q  <= item.char_in;
      hit_q <= (item.operation == cte_pkg::OP_READ) && in_text;
    end
    if (state == cte_pkg::S_EXEC) begin
      result.char_out    <= hit_q ? mem_rd_data : 8'd0;
      result.char_valid  <= hit_q;
      result.cursor_pos  <= left_next_x[10:0];
      result.text_length <= len_next_x[10:0];
      result.status      <= status_next;
    end
  end

endmodule

// ----- hw/rtl/cursor_text_buffer.sv -----
// cursor text buffer top level: gap buffer over one byte memory
//
// A line-edit buffer with a cursor. Text left of the cursor sits at the low
// end of a CAPACITY-byte memory, text right of it at the high end. Raise
// start with an item; it is taken at an edge where busy is low. Every item
// goes through the registered read of the memory (the byte that a cursor
// move carries across the gap, or the byte being read), then the EXEC
// state, which writes back and updates the counters and during which busy
// is high. The result beat appears on result with done high for exactly
// one cycle, the cycle after that, and must be taken then: there is no
// back-pressure. A new item can be started in that same cycle; no new item
// is taken while busy is high. The memory holds no reset value and needs
// no clearing pass; the block is ready right after reset.
module cursor_text_buffer #(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cte_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output cte_pkg::result_t result
);

  localparam int AW = $clog2(CAPACITY);

  // memory port wires
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // sequencer: accepts items, drives the memory, builds result beats
  cte_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .done        (done),
    .result      (result),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data)
  );

  // byte store; busy blocks a new read until the pending write has landed
  cte_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ----- hw/rtl/cte_check.sv -----
// port-level checks for the cursor text buffer, bound to the top level
module cte_check (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input cte_pkg::result_t result
);

  // an accepted item raises busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // every accepted item gives its result beat after the EXEC state
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result beat missing after accept");

  // a result beat only follows a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result beat without work cycle");

  // cursor never lies beyond the end of the text
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.cursor_pos <= result.text_length))
    else $error("cursor beyond text length");

  // a valid read byte always comes with done status
  assert property (@(posedge clk) disable iff (rst)
    (done && result.char_valid) |-> (result.status == cte_pkg::ST_DONE))
    else $error("valid read with error status");

endmodule

bind cursor_text_buffer cte_check u_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
